>>> rtl/rlbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbe_pkg
// Shared types and constants for the run-length byte encoder.
// ----------------------------------------------------------------------------
package rlbe_pkg;

    localparam int SYM_W   = 7;
    localparam int CNT_W   = 16;
    localparam int BYTE_W  = 8;

    localparam logic [CNT_W-1:0] RUN_CAP = 16'hFFFF;

    // Input command codes (carried on s_tuser)
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One entry of work for the back end: a run record or an error marker.
    typedef struct packed {
        logic             err;
        logic             wide;   // count above one byte, three-byte record
        logic [SYM_W-1:0] sym;
        logic [CNT_W-1:0] cnt;
    } rlbe_job_t;

endpackage

>>> rtl/rlbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbe_front
// Accepts items, tracks the open run and hands finished runs and errors to
// the job queue.
// ----------------------------------------------------------------------------
module rlbe_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] symbol
    input  logic [0:0]           s_tuser,   // [0] command
    input  logic                 q_full,
    output logic                 q_push,
    output rlbe_pkg::rlbe_job_t  q_job
);
    import rlbe_pkg::*;

    logic [SYM_W-1:0] run_sym_reg, run_sym_next;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic             run_open_reg, run_open_next;
    logic             accept;
    logic             extend;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign extend   = run_open_reg && (s_tdata[SYM_W-1:0] == run_sym_reg)
                      && (run_cnt_reg < RUN_CAP);

    always_comb begin
        run_sym_next  = run_sym_reg;
        run_cnt_next  = run_cnt_reg;
        run_open_next = run_open_reg;
        q_push        = 1'b0;
        q_job.err     = 1'b0;
        q_job.wide    = (run_cnt_reg[CNT_W-1:BYTE_W] != '0);
        q_job.sym     = run_sym_reg;
        q_job.cnt     = run_cnt_reg;
        if (accept) begin
            if (s_tuser[0] == CMD_FLUSH) begin
                q_push        = run_open_reg;
                run_sym_next  = '0;
                run_cnt_next  = '0;
                run_open_next = 1'b0;
            end else if (s_tdata[BYTE_W-1]) begin
                // out-of-range symbol: error marker, run untouched
                q_push    = 1'b1;
                q_job.err = 1'b1;
            end else if (extend) begin
                run_cnt_next = run_cnt_reg + 1'b1;
            end else begin
                q_push        = run_open_reg;
                run_sym_next  = s_tdata[SYM_W-1:0];
                run_cnt_next  = {{(CNT_W-1){1'b0}}, 1'b1};
                run_open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sym_reg  <= '0;
            run_cnt_reg  <= '0;
            run_open_reg <= 1'b0;
        end else begin
            run_sym_reg  <= run_sym_next;
            run_cnt_reg  <= run_cnt_next;
            run_open_reg <= run_open_next;
        end
    end

    // an open run always holds at least one symbol
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg |-> (run_cnt_reg != '0))
        else $error("open run with zero count");

endmodule

>>> rtl/rlbe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbe_queue
// Short FIFO of jobs between the front and the back end.
// ----------------------------------------------------------------------------
module rlbe_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rlbe_pkg::rlbe_job_t  push_job,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output rlbe_pkg::rlbe_job_t  head_job
);
    import rlbe_pkg::*;

    rlbe_job_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job queue underflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("job queue count out of range");

endmodule

>>> rtl/rlbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbe_back
// Takes jobs from the queue and serializes each into record bytes.
// ----------------------------------------------------------------------------
module rlbe_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  rlbe_pkg::rlbe_job_t  q_job,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic                 m_tlast,   // last
    output logic [0:0]           m_tuser    // [0] error
);
    import rlbe_pkg::*;

    localparam logic [1:0] POS_SYM = 2'd0;
    localparam logic [1:0] POS_LO  = 2'd1;
    localparam logic [1:0] POS_HI  = 2'd2;

    rlbe_job_t  job_reg;
    logic       job_valid_reg, job_valid_next;
    logic [1:0] pos_reg, pos_next;
    logic       byte_last;
    logic       xfer;

    always_comb begin
        m_tdata   = '0;
        byte_last = 1'b0;
        if (job_reg.err) begin
            byte_last = 1'b1;
        end else begin
            case (pos_reg)
                POS_SYM: m_tdata = {job_reg.wide, job_reg.sym};
                POS_LO: begin
                    m_tdata   = job_reg.cnt[BYTE_W-1:0];
                    byte_last = !job_reg.wide;
                end
                POS_HI: begin
                    m_tdata   = job_reg.cnt[CNT_W-1:BYTE_W];
                    byte_last = 1'b1;
                end
                default: begin
                    m_tdata   = '0;
                    byte_last = 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid   = job_valid_reg;
    assign m_tlast    = byte_last;
    assign m_tuser[0] = job_reg.err;
    assign xfer       = m_tvalid && m_tready;
    // next job loads as soon as the last byte of the current one leaves
    assign q_pop      = q_valid && (!job_valid_reg || (xfer && byte_last));

    always_comb begin
        job_valid_next = job_valid_reg;
        pos_next       = pos_reg;
        if (q_pop) begin
            job_valid_next = 1'b1;
            pos_next       = POS_SYM;
        end else if (xfer) begin
            if (byte_last) begin
                job_valid_next = 1'b0;
                pos_next       = POS_SYM;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            pos_reg       <= POS_SYM;
        end else begin
            job_valid_reg <= job_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
        else $error("error result must be a single zero byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !job_reg.err && !job_reg.wide) |-> (pos_reg != POS_HI))
        else $error("short record past its count byte");

endmodule

>>> rtl/run_length_byte_encoder_core.sv
`timescale 1ns / 1ps
// A closed run goes through the job queue and the back job register before its first byte.
// Throughput: one input item per cycle; a queued record drains at one byte per cycle
// while m_tready is high (2 or 3 bytes, 1 for an error), back to back between records.
// The front stalls only when the 4-entry job queue is full.
// Reset: synchronous active-low aresetn clears the open run, the queue and the output.
// ----------------------------------------------------------------------------
// run_length_byte_encoder_core
// Run-length encoder for 7-bit symbols with byte-serial record output.
// ----------------------------------------------------------------------------
module run_length_byte_encoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [0:0] s_tuser,   // [0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // last
    output logic [0:0] m_tuser    // [0] error
);
    import rlbe_pkg::*;

    logic      q_push, q_full, q_pop, q_valid;
    rlbe_job_t push_job, head_job;

    rlbe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    rlbe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    rlbe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
